### hdl/dlsr_pkg.sv
// ----------------------------------------------------------------------------
// dlsr_pkg
// shared constants, types and state codes for the dynamic label segment
// reassembler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlsr_pkg;

	localparam int MAX_SEGMENTS  = 8;
	localparam int MAX_SEG_CHARS = 16;

	localparam int SEG_IDX_W = 3;
	localparam int LEN_W     = 5;
	localparam int ROW_W     = 128;
	localparam int WORD_W    = 64;
	localparam int WORD_BYTES = 8;

	// header bit masks
	localparam logic [7:0] HDR_TOGGLE  = 8'h80;
	localparam logic [7:0] HDR_FIRST   = 8'h40;
	localparam logic [7:0] HDR_LAST    = 8'h20;
	localparam logic [7:0] HDR_COMMAND = 8'h10;
	localparam logic [7:0] HDR_NIBBLE  = 8'h0F;
	localparam logic [7:0] HDR_SEGNUM  = 8'h70;

	localparam logic [3:0] CMD_CLEAR_DISPLAY = 4'h1;

	localparam logic RESULT_WORD  = 1'b0;
	localparam logic RESULT_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_CHECK,
		ST_READ,
		ST_LO,
		ST_HI
	} dlsr_state_t;

	// one request from the sequencer to the word packer
	typedef struct packed {
		logic        valid;
		logic        clr;
		logic        final_half;
		logic [3:0]  nbytes;
		logic [3:0]  charset;
		logic [63:0] data;
	} pack_cmd_t;

endpackage

`default_nettype wire

### hdl/dlsr_seg_ram.sv
// ----------------------------------------------------------------------------
// dlsr_seg_ram
// segment byte store: one row of sixteen characters per segment number,
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlsr_seg_ram
	import dlsr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [SEG_IDX_W-1:0] waddr,
	input  wire logic [ROW_W-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [SEG_IDX_W-1:0] raddr,
	output logic      [ROW_W-1:0]     rdata
);

	logic [ROW_W-1:0] mem [MAX_SEGMENTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/dlsr_word_packer.sv
// ----------------------------------------------------------------------------
// dlsr_word_packer
// gathers segment halves into 8-byte label words and holds the output beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlsr_word_packer
	import dlsr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire pack_cmd_t   cmd,
	output logic             cmd_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             result_kind,
	output logic [3:0]       charset,
	output logic [63:0]      label_word,
	output logic [3:0]       byte_count,
	output logic             last_word
);

	logic              out_valid_q;
	logic              flush_q;
	logic [2:0]        pend_cnt_q;
	logic [63:0]       pend_q;
	logic [3:0]        cs_q;
	logic              out_free;
	logic              take;
	logic [63:0]       masked;
	logic [127:0]      merged;
	logic [3:0]        total;

	assign out_free  = !out_valid_q || out_ready;
	assign cmd_ready = out_free && !flush_q;
	assign take      = cmd.valid && cmd_ready;

	always_comb begin
		for (int b = 0; b < WORD_BYTES; b++) begin
			masked[b*8 +: 8] = (4'(b) < cmd.nbytes) ? cmd.data[b*8 +: 8] : 8'h00;
		end
		merged = {64'h0, pend_q} | ({64'h0, masked} << {pend_cnt_q, 3'b000});
		total  = {1'b0, pend_cnt_q} + cmd.nbytes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			flush_q     <= 1'b0;
			pend_cnt_q  <= '0;
			pend_q      <= '0;
			cs_q        <= '0;
		end else begin
			if (flush_q && out_free) begin
				out_valid_q <= 1'b1;
				flush_q     <= 1'b0;
				pend_cnt_q  <= '0;
				pend_q      <= '0;
			end else if (take) begin
				if (cmd.clr) begin
					out_valid_q <= 1'b1;
				end else begin
					cs_q <= cmd.charset;
					if (total >= 4'(WORD_BYTES)) begin
						out_valid_q <= 1'b1;
						pend_q      <= merged[127:64];
						pend_cnt_q  <= 3'(total - 4'(WORD_BYTES));
						flush_q     <= cmd.final_half && (total != 4'(WORD_BYTES));
					end else if (cmd.final_half) begin
						out_valid_q <= 1'b1;
						pend_q      <= '0;
						pend_cnt_q  <= '0;
					end else begin
						out_valid_q <= 1'b0;
						pend_q      <= merged[63:0];
						pend_cnt_q  <= total[2:0];
					end
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (flush_q && out_free) begin
			result_kind <= RESULT_WORD;
			charset     <= cs_q;
			label_word  <= pend_q;
			byte_count  <= {1'b0, pend_cnt_q};
			last_word   <= 1'b1;
		end else if (take) begin
			if (cmd.clr) begin
				result_kind <= RESULT_CLEAR;
				charset     <= '0;
				label_word  <= '0;
				byte_count  <= '0;
				last_word   <= 1'b1;
			end else if (total >= 4'(WORD_BYTES)) begin
				result_kind <= RESULT_WORD;
				charset     <= cmd.charset;
				label_word  <= merged[63:0];
				byte_count  <= 4'(WORD_BYTES);
				last_word   <= cmd.final_half && (total == 4'(WORD_BYTES));
			end else if (cmd.final_half) begin
				result_kind <= RESULT_WORD;
				charset     <= cmd.charset;
				label_word  <= merged[63:0];
				byte_count  <= total;
				last_word   <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### hdl/dynamic_label_segment_reassembler.sv
// ----------------------------------------------------------------------------
// dynamic_label_segment_reassembler
// caches label segments in a segment memory and emits the completed label
// as 8-byte words with its charset
// ----------------------------------------------------------------------------
// out_valid for a remove-label beat is set by the packer from ST_CLEAR; for a
//   completing segment the sequencer passes ST_CHECK, ST_READ and ST_LO before
//   the packer can register a word; output stalls hold ST_CLEAR, ST_LO and ST_HI
// in_ready is low in ST_CHECK after a stored segment and in ST_CLEAR after a
//   remove-label beat; a completed label holds it low through ST_READ, ST_LO
//   and, for a segment over 8 chars, ST_HI per segment, via the one read port
// reset: segment flags, toggle and charset clear at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module dynamic_label_segment_reassembler
	import dlsr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  header_first,
	input  wire logic [7:0]  header_second,
	input  wire logic [63:0] chars_low,
	input  wire logic [63:0] chars_high,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             result_kind,
	output logic [3:0]       charset,
	output logic [63:0]      label_word,
	output logic [3:0]       byte_count,
	output logic             last_word
);

	dlsr_state_t state_q, state_nxt;

	logic [MAX_SEGMENTS-1:0] seg_valid_q;
	logic [MAX_SEGMENTS-1:0] seg_last_q;
	logic [LEN_W-1:0]        seg_len_q [MAX_SEGMENTS];
	logic                    toggle_q;
	logic [3:0]              charset_q;
	logic [SEG_IDX_W-1:0]    seg_idx_q;
	logic [SEG_IDX_W-1:0]    end_idx_q;

	logic                    accept;
	logic                    is_cmd;
	logic                    is_remove;
	logic                    in_toggle;
	logic                    cache_flush;
	logic [MAX_SEGMENTS-1:0] valid_eff;
	logic [MAX_SEGMENTS-1:0] last_eff;
	logic [SEG_IDX_W-1:0]    segnum;
	logic [LEN_W-1:0]        new_len;
	logic                    store;

	logic                    done;
	logic [SEG_IDX_W-1:0]    done_idx;
	logic                    chain_ok;

	logic [LEN_W-1:0]        cur_len;
	logic                    long_seg;
	logic                    at_end;

	logic                    mem_we;
	logic                    mem_re;
	logic [ROW_W-1:0]        mem_rdata;
	pack_cmd_t               pk_cmd;
	logic                    pk_ready;

	// input decode
	always_comb begin
		accept      = in_valid && in_ready;
		is_cmd      = (header_first & HDR_COMMAND) != 8'h00;
		is_remove   = (header_first[3:0] == CMD_CLEAR_DISPLAY);
		in_toggle   = (header_first & HDR_TOGGLE) != 8'h00;
		cache_flush = (|seg_valid_q) && (in_toggle != toggle_q);
		valid_eff   = cache_flush ? '0 : seg_valid_q;
		last_eff    = cache_flush ? '0 : seg_last_q;
		segnum      = ((header_first & HDR_FIRST) != 8'h00) ? '0
			: SEG_IDX_W'((header_second & HDR_SEGNUM) >> 4);
		new_len     = LEN_W'(header_first & HDR_NIBBLE) + LEN_W'(1);
		if (new_len > LEN_W'(MAX_SEG_CHARS)) begin
			new_len = LEN_W'(MAX_SEG_CHARS);
		end
		store       = (int'(segnum) < MAX_SEGMENTS) && !valid_eff[segnum];
	end

	// completion scan over the segment flags
	always_comb begin
		done     = 1'b0;
		done_idx = '0;
		chain_ok = 1'b1;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			if (chain_ok && !done) begin
				if (!seg_valid_q[i]) begin
					chain_ok = 1'b0;
				end else if (seg_last_q[i]) begin
					done     = 1'b1;
					done_idx = SEG_IDX_W'(i);
				end
			end
		end
	end

	always_comb begin
		cur_len  = seg_len_q[seg_idx_q];
		long_seg = cur_len > LEN_W'(WORD_BYTES);
		at_end   = seg_idx_q == end_idx_q;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_cmd) begin
						state_nxt = is_remove ? ST_CLEAR : ST_IDLE;
					end else begin
						state_nxt = store ? ST_CHECK : ST_IDLE;
					end
				end
			end
			ST_CLEAR: begin
				if (pk_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_CHECK: begin
				state_nxt = done ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				state_nxt = ST_LO;
			end
			ST_LO: begin
				if (pk_ready) begin
					if (long_seg) begin
						state_nxt = ST_HI;
					end else begin
						state_nxt = at_end ? ST_IDLE : ST_READ;
					end
				end
			end
			ST_HI: begin
				if (pk_ready) begin
					state_nxt = at_end ? ST_IDLE : ST_READ;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		pk_cmd   = '0;
		pk_cmd.charset = charset_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				mem_we   = accept && !is_cmd && store;
			end
			ST_CLEAR: begin
				pk_cmd.valid      = 1'b1;
				pk_cmd.clr        = 1'b1;
				pk_cmd.final_half = 1'b1;
			end
			ST_CHECK: begin
			end
			ST_READ: begin
				mem_re = 1'b1;
			end
			ST_LO: begin
				pk_cmd.valid      = 1'b1;
				pk_cmd.data       = mem_rdata[63:0];
				pk_cmd.nbytes     = long_seg ? 4'(WORD_BYTES) : cur_len[3:0];
				pk_cmd.final_half = at_end && !long_seg;
			end
			ST_HI: begin
				pk_cmd.valid      = 1'b1;
				pk_cmd.data       = mem_rdata[127:64];
				pk_cmd.nbytes     = 4'(cur_len - LEN_W'(WORD_BYTES));
				pk_cmd.final_half = at_end;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seg_valid_q <= '0;
			seg_last_q  <= '0;
			toggle_q    <= 1'b0;
			charset_q   <= '0;
			seg_idx_q   <= '0;
			end_idx_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE && accept && !is_cmd) begin
				seg_valid_q <= valid_eff | (MAX_SEGMENTS'(store) << segnum);
				seg_last_q  <= last_eff | (MAX_SEGMENTS'(store
					&& ((header_first & HDR_LAST) != 8'h00)) << segnum);
				if (store) begin
					toggle_q <= in_toggle;
					if (segnum == '0) begin
						charset_q <= header_second[7:4];
					end
				end
			end
			if (state_q == ST_CHECK) begin
				seg_idx_q <= '0;
				end_idx_q <= done_idx;
			end
			if (pk_ready && ((state_q == ST_LO && !long_seg) || state_q == ST_HI)) begin
				seg_idx_q <= seg_idx_q + SEG_IDX_W'(1);
			end
		end
	end

	// segment lengths, only read for held segments
	always_ff @(posedge clk) begin
		if (mem_we) begin
			seg_len_q[segnum] <= new_len;
		end
	end

	dlsr_seg_ram u_seg_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (segnum),
		.wdata ({chars_high, chars_low}),
		.re    (mem_re),
		.raddr (seg_idx_q),
		.rdata (mem_rdata)
	);

	dlsr_word_packer u_packer (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (pk_cmd),
		.cmd_ready   (pk_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.charset     (charset),
		.label_word  (label_word),
		.byte_count  (byte_count),
		.last_word   (last_word)
	);

	// the sequencer never writes and reads the segment memory together
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !mem_re)
		else $error("segment memory written and read in one cycle");

	// only held segments are read back
	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> seg_valid_q[seg_idx_q])
		else $error("read of a segment that is not held");

	// the walk never passes the closing segment
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LO || state_q == ST_HI || state_q == ST_READ)
		|-> seg_idx_q <= end_idx_q)
		else $error("segment walk past the last segment");

	// a second half is only sent for a segment longer than one word
	a_hi_long: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HI |-> long_seg)
		else $error("upper half sent for a short segment");

endmodule

`default_nettype wire

### test/dynamic_label_segment_reassembler_tb.sv
// ----------------------------------------------------------------------------
// dynamic_label_segment_reassembler_tb
// drives data groups through the reassembler under random bursts and output
// stalls, predicts every label and clear beat from a segment cache of its own
// and checks each output beat field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dynamic_label_segment_reassembler_tb;
	import dlsr_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_GROUPS = 96;

	typedef struct {
		logic [7:0]  h0;
		logic [7:0]  h1;
		logic [63:0] lo;
		logic [63:0] hi;
		bit          drain;
	} data_group_t;

	typedef struct {
		logic        kind;
		logic [3:0]  cs;
		logic [63:0] word;
		logic [3:0]  count;
		logic        last;
	} label_beat_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [7:0]  header_first  = '0;
	logic [7:0]  header_second = '0;
	logic [63:0] chars_low     = '0;
	logic [63:0] chars_high    = '0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic        result_kind;
	logic [3:0]  charset;
	logic [63:0] label_word;
	logic [3:0]  byte_count;
	logic        last_word;

	data_group_t pending_groups[$];
	label_beat_t expected_beats[$];
	data_group_t next_group;
	label_beat_t want_beat;
	int          errors     = 0;
	int          cycles     = 0;
	int          gap_left   = 0;
	int          burst_left = 0;
	logic [5:0]  ready_phase = '0;
	logic [1:0]  ready_mode  = '0;

	// segment cache mirror
	logic [7:0]  held_mask;
	logic [7:0]  last_mask;
	int          seg_len [MAX_SEGMENTS];
	logic [7:0]  seg_chars [MAX_SEGMENTS][MAX_SEG_CHARS];
	logic        held_toggle;
	logic [3:0]  label_charset;

	dynamic_label_segment_reassembler dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.header_first(header_first),
		.header_second(header_second),
		.chars_low(chars_low),
		.chars_high(chars_high),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.charset(charset),
		.label_word(label_word),
		.byte_count(byte_count),
		.last_word(last_word)
	);

	always #4 clk = ~clk;

	task automatic predict_group(input logic [7:0] h0, input logic [7:0] h1,
			input logic [63:0] lo, input logic [63:0] hi);
		logic [127:0] chars;
		logic         tog;
		logic [2:0]   seg;
		int           nchars;
		int           nsegs;
		logic [7:0]   text[$];
		label_beat_t  beat;
		chars = {hi, lo};
		tog = (h0 & HDR_TOGGLE) != 0;
		if ((h0 & HDR_COMMAND) != 0) begin
			if ((h0 & HDR_NIBBLE) == CMD_CLEAR_DISPLAY) begin
				beat = '{RESULT_CLEAR, 4'd0, 64'd0, 4'd0, 1'b1};
				expected_beats.push_back(beat);
			end
			return;
		end
		if (held_mask != 0 && held_toggle != tog) begin
			held_mask = '0;
			last_mask = '0;
		end
		seg = ((h0 & HDR_FIRST) != 0) ? 3'd0 : 3'((h1 & HDR_SEGNUM) >> 4);
		if (int'(seg) >= MAX_SEGMENTS || held_mask[seg])
			return;
		nchars = int'(h0 & HDR_NIBBLE) + 1;
		if (nchars > MAX_SEG_CHARS)
			nchars = MAX_SEG_CHARS;
		for (int i = 0; i < nchars; i++)
			seg_chars[seg][i] = chars[8*i +: 8];
		seg_len[seg] = nchars;
		last_mask[seg] = (h0 & HDR_LAST) != 0;
		held_mask[seg] = 1'b1;
		held_toggle = tog;
		if (seg == 0)
			label_charset = h1[7:4];
		// label is complete once segments 0..k are held and k is flagged last
		nsegs = 0;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			if (!held_mask[i])
				return;
			if (last_mask[i]) begin
				nsegs = i + 1;
				break;
			end
		end
		if (nsegs == 0)
			return;
		for (int i = 0; i < nsegs; i++)
			for (int j = 0; j < seg_len[i]; j++)
				text.push_back(seg_chars[i][j]);
		for (int pos = 0; pos < text.size(); pos += 8) begin
			beat.kind  = RESULT_WORD;
			beat.cs    = label_charset;
			beat.word  = '0;
			beat.count = 4'((text.size() - pos > 8) ? 8 : text.size() - pos);
			for (int b = 0; b < int'(beat.count); b++)
				beat.word[8*b +: 8] = text[pos + b];
			beat.last  = (pos + int'(beat.count)) >= text.size();
			expected_beats.push_back(beat);
		end
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] seg_header(bit tog, bit first, bit last, int nchars);
		logic [7:0] h;
		h = 8'(nchars - 1) & HDR_NIBBLE;
		if (tog)
			h = h | HDR_TOGGLE;
		if (first)
			h = h | HDR_FIRST;
		if (last)
			h = h | HDR_LAST;
		return h;
	endfunction

	task automatic add_group(logic [7:0] h0, logic [7:0] h1, logic [63:0] lo,
			logic [63:0] hi, bit drain);
		data_group_t g;
		g = '{h0, h1, lo, hi, drain};
		pending_groups.push_back(g);
	endtask

	task automatic add_segment(bit tog, int seg, bit last, int nchars, bit drain);
		bit         first;
		logic [7:0] h1;
		first = (seg == 0) && ($urandom_range(0, 3) != 0);
		h1 = 8'($urandom);
		if (!first)
			h1 = (h1 & ~HDR_SEGNUM) | (8'(seg) << 4);
		add_group(seg_header(tog, first, last, nchars), h1, rand_word(), rand_word(), drain);
	endtask

	// one label in shuffled segment order, now and then with a flaw
	task automatic add_message(bit tog);
		int nsegs;
		int flaw;
		int k;
		int tmp;
		int order[$];
		nsegs = ($urandom_range(0, 3) == 0) ? $urandom_range(4, MAX_SEGMENTS)
			: $urandom_range(1, 3);
		for (int s = 0; s < nsegs; s++)
			order.push_back(s);
		for (int s = nsegs - 1; s > 0; s--) begin
			k = $urandom_range(0, s);
			tmp = order[s];
			order[s] = order[k];
			order[k] = tmp;
		end
		flaw = $urandom_range(0, 9);
		if (flaw == 0)
			void'(order.pop_back());
		else if (flaw == 1)
			order.push_back(order[0]);
		else if (flaw == 2 && nsegs < MAX_SEGMENTS)
			order.push_back($urandom_range(nsegs, MAX_SEGMENTS - 1));
		for (int s = 0; s < order.size(); s++)
			add_segment(tog, order[s], order[s] == nsegs - 1 && flaw != 3,
				$urandom_range(1, MAX_SEG_CHARS), s == 0 && $urandom_range(0, 3) == 0);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
			burst_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_groups.size() == 0 ||
					(pending_groups[0].drain && (in_valid || expected_beats.size() != 0))) begin
				in_valid <= 1'b0;
			end else begin
				next_group = pending_groups.pop_front();
				in_valid <= 1'b1;
				header_first <= next_group.h0;
				header_second <= next_group.h1;
				chars_low <= next_group.lo;
				chars_high <= next_group.hi;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
				end else
					burst_left <= burst_left - 1;
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_phase <= '0;
			ready_mode <= '0;
		end else begin
			ready_phase <= ready_phase + 1'b1;
			if (ready_phase == 0)
				ready_mode <= 2'($urandom_range(0, 3));
			case (ready_mode)
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= ($urandom_range(0, 3) != 0);
				2'd2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ready_phase[3];
			endcase
		end
	end

	// predictor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_mask = '0;
			last_mask = '0;
			held_toggle = 1'b0;
			label_charset = '0;
		end else begin
			if (in_valid && in_ready)
				predict_group(header_first, header_second, chars_low, chars_high);
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected beat, expected none, got kind %0d word %h count %0d",
						$time, result_kind, label_word, byte_count);
					errors++;
				end else begin
					want_beat = expected_beats.pop_front();
					check_field("result_kind", want_beat.kind, result_kind);
					check_field("charset", want_beat.cs, charset);
					check_field("label_word", want_beat.word, label_word);
					check_field("byte_count", want_beat.count, byte_count);
					check_field("last_word", want_beat.last, last_word);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("dynamic_label_segment_reassembler_tb failed");
			$finish;
		end
	end

	initial begin
		int  directed_count;
		bit  tog;
		int  pick;
		// remove label, then ignored commands
		add_group(HDR_COMMAND | 8'(CMD_CLEAR_DISPLAY), 8'hFF, rand_word(), rand_word(), 0);
		add_group(HDR_TOGGLE | HDR_FIRST | HDR_LAST | HDR_COMMAND | HDR_NIBBLE, 8'($urandom),
			rand_word(), rand_word(), 0);
		add_group(HDR_COMMAND, 8'h00, 64'd0, 64'd0, 0);
		// single full segment, then a duplicate and a repeat completion
		add_group(seg_header(0, 1, 1, 16), 8'hF0, '1, '1, 0);
		add_group(seg_header(0, 1, 1, 1), 8'h00, 64'd0, 64'd0, 1);
		add_group(seg_header(0, 0, 0, 1), 8'hD0, rand_word(), rand_word(), 0);
		// toggle change, out-of-order three segment label
		add_group(seg_header(1, 1, 0, 1), 8'h00, 64'd0, 64'd0, 0);
		add_group(seg_header(1, 0, 1, 3), 8'h2F, rand_word(), rand_word(), 0);
		add_group(seg_header(1, 0, 0, 8), 8'h9A, rand_word(), rand_word(), 0);
		// first flag wins over segment bits
		add_group(seg_header(0, 1, 1, 9), 8'h70, rand_word(), rand_word(), 1);
		// all segments held, none last
		for (int s = 0; s < MAX_SEGMENTS; s++)
			add_group(seg_header(1, 0, 0, 16), {1'b0, 3'(s), 4'h5}, rand_word(), rand_word(), 0);
		// longest label, segment zero last
		for (int s = MAX_SEGMENTS - 1; s > 0; s--)
			add_group(seg_header(0, 0, s == MAX_SEGMENTS - 1, 16), {1'b1, 3'(s), 4'hA},
				rand_word(), rand_word(), s == MAX_SEGMENTS - 1);
		add_group(seg_header(0, 1, 0, 16), 8'hC3, rand_word(), rand_word(), 0);
		directed_count = pending_groups.size();

		tog = 1'b0;
		while (pending_groups.size() < directed_count + RANDOM_GROUPS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				add_group(8'($urandom), 8'($urandom), rand_word(), rand_word(), 0);
			else if (pick == 1)
				add_group((8'($urandom) & ~HDR_NIBBLE) | HDR_COMMAND |
					(($urandom_range(0, 1) == 0) ? 8'(CMD_CLEAR_DISPLAY)
					: (8'($urandom) & HDR_NIBBLE)), 8'($urandom), rand_word(), rand_word(), 0);
			else begin
				if ($urandom_range(0, 4) != 0)
					tog = !tog;
				add_message(tog);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_groups.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("dynamic_label_segment_reassembler_tb passed");
		else
			$display("dynamic_label_segment_reassembler_tb failed");
		$finish;
	end

endmodule
